[src/pps_pkg.sv]
// Shared types and fixed field widths for the preemptive priority scheduler.
// No dependencies; every other file of the block refers to this package by scope.
package pps_pkg;

	// Fixed widths of the port fields
	localparam int IN_TIME_W  = 16;
	localparam int IN_PRIO_W  = 8;
	localparam int OUT_INDEX_W = 4;
	localparam int OUT_COMP_W = 21;
	localparam int OUT_TURN_W = 20;

	// Entries of the record queue between front and back (power of two)
	localparam int Q_DEPTH = 4;

	typedef struct packed {
		logic [IN_TIME_W-1:0] arrival_time;
		logic [IN_TIME_W-1:0] burst_length;
		logic [IN_PRIO_W-1:0] job_priority;
		logic                 final_job;
	} job_t;

	typedef struct packed {
		logic [OUT_INDEX_W-1:0] job_index;
		logic [OUT_COMP_W-1:0]  completion_time;
		logic [OUT_TURN_W-1:0]  turnaround_time;
		logic [OUT_TURN_W-1:0]  waiting_time;
		logic                   last_result;
	} result_t;

	// Queue handshake seen by the producer and the consumer
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

[src/pps_front.sv]
// Front end: takes job records, masks them to the configured widths and tags
// zero-burst and end-of-batch records. Depends on pps_pkg.
module pps_front #(
	parameter int MAX_JOBS       = 16,
	parameter int TIME_WIDTH     = 16,
	parameter int PRIORITY_WIDTH = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  pps_pkg::job_t                            job,
	input  pps_pkg::q_status_t                       q_status,
	output logic                                     push,
	output logic [2*TIME_WIDTH+PRIORITY_WIDTH+1:0]   push_data
);

	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int TX_W  = (TIME_WIDTH > pps_pkg::IN_TIME_W) ? TIME_WIDTH : pps_pkg::IN_TIME_W;
	localparam int PX_W  = (PRIORITY_WIDTH > pps_pkg::IN_PRIO_W) ?
		PRIORITY_WIDTH : pps_pkg::IN_PRIO_W;

	logic [IDX_W-1:0]          batch_q;
	logic [TX_W-1:0]           arr_x;
	logic [TX_W-1:0]           burst_x;
	logic [PX_W-1:0]           prio_x;
	logic [TIME_WIDTH-1:0]     arr;
	logic [TIME_WIDTH-1:0]     burst;
	logic [PRIORITY_WIDTH-1:0] prio;
	logic                      zero_burst;
	logic                      batch_end;

	assign busy    = q_status.full;
	assign push    = start && !q_status.full;

	assign arr_x   = TX_W'(job.arrival_time);
	assign burst_x = TX_W'(job.burst_length);
	assign prio_x  = PX_W'(job.job_priority);
	assign arr     = arr_x[TIME_WIDTH-1:0];
	assign burst   = burst_x[TIME_WIDTH-1:0];
	assign prio    = prio_x[PRIORITY_WIDTH-1:0];

	// A record that fills the last slot closes the batch by itself
	assign zero_burst = (burst == '0);
	assign batch_end  = job.final_job || (batch_q == IDX_W'(MAX_JOBS - 1));

	assign push_data = {arr, burst, prio, zero_burst, batch_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q <= '0;
		end else if (push) begin
			batch_q <= batch_end ? '0 : batch_q + IDX_W'(1);
		end
	end

endmodule

[src/pps_queue.sv]
// Short first-in first-out queue of classified job records.
// Depends on pps_pkg for its depth and status type.
module pps_queue #(
	parameter int W = 42
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [W-1:0]       push_data,
	input  logic               pop,
	output logic [W-1:0]       head,
	output pps_pkg::q_status_t q_status
);

	localparam int PTR_W = (pps_pkg::Q_DEPTH > 1) ? $clog2(pps_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(pps_pkg::Q_DEPTH + 1);

	logic [W-1:0]     mem_q [pps_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head           = mem_q[rd_ptr_q];
	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == CNT_W'(pps_pkg::Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/pps_back.sv]
// Back end: loads records from the queue into job memories, runs the
// event-driven scheduling loop and streams one result per job. Depends on pps_pkg.
module pps_back #(
	parameter int MAX_JOBS       = 16,
	parameter int TIME_WIDTH     = 16,
	parameter int PRIORITY_WIDTH = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pps_pkg::q_status_t                     q_status,
	input  logic [2*TIME_WIDTH+PRIORITY_WIDTH+1:0] q_head,
	output logic                                   q_pop,
	output logic                                   strobe,
	output pps_pkg::result_t                       result
);

	localparam int TW     = TIME_WIDTH;
	localparam int PW     = PRIORITY_WIDTH;
	localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W  = $clog2(MAX_JOBS + 1);
	localparam int SIM_W  = TW + $clog2(MAX_JOBS + 1);
	localparam int REC_W  = 2*TW + PW;
	localparam int STAT_W = TW + SIM_W;
	localparam int IX_W   = (IDX_W > pps_pkg::OUT_INDEX_W) ? IDX_W : pps_pkg::OUT_INDEX_W;
	localparam int CX_W   = (SIM_W > pps_pkg::OUT_COMP_W) ? SIM_W : pps_pkg::OUT_COMP_W;
	localparam int TX_W   = (SIM_W > pps_pkg::OUT_TURN_W) ? SIM_W : pps_pkg::OUT_TURN_W;
	localparam logic [PW:0] PRIO_NONE = {1'b1, {PW{1'b0}}};

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CHECK,
		ST_SCAN,
		ST_SPAN,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Job memories
	logic [REC_W-1:0]  rec_mem  [MAX_JOBS];
	logic [STAT_W-1:0] stat_mem [MAX_JOBS];
	logic [REC_W-1:0]  rec_rd_q;
	logic [STAT_W-1:0] stat_rd_q;

	// Scheduler state
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  done_q;
	logic [CNT_W-1:0]  idx_q;
	logic [SIM_W-1:0]  t_q;
	logic [IDX_W-1:0]  run_job_q;
	logic              run_valid_q;
	logic [PW:0]       run_prio_q;
	logic [TW-1:0]     run_rem_q;
	logic [TW-1:0]     span_q;

	// Scan accumulators
	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PW:0]       best_prio_q;
	logic [TW-1:0]     best_rem_q;
	logic              nxt_found_q;
	logic [TW-1:0]     nxt_q;

	// Scan and emit pipelines
	logic              eval_v_s1;
	logic [IDX_W-1:0]  eval_idx_s1;
	logic              em_v_s1;
	logic [IDX_W-1:0]  em_idx_s1;
	logic              em_last_s1;
	logic              em_v_s2;
	logic [IDX_W-1:0]  em_idx_s2;
	logic              em_last_s2;
	logic [SIM_W-1:0]  comp_s2;
	logic [SIM_W-1:0]  tat_s2;
	logic [TW-1:0]     burst_s2;
	logic              strobe_q;
	pps_pkg::result_t  result_q;

	// Queue head fields
	logic [TW-1:0]     h_arr;
	logic [TW-1:0]     h_burst;
	logic [PW-1:0]     h_prio;
	logic              h_zero;
	logic              h_last;

	// Read data fields
	logic [TW-1:0]     r_arr;
	logic [TW-1:0]     r_burst;
	logic [PW-1:0]     r_prio;
	logic [TW-1:0]     r_rem;
	logic [SIM_W-1:0]  r_comp;

	logic              arrived;
	logic              live;
	logic              take;
	logic              nxt_take;
	logic              eval_last;
	logic              issue_last;
	logic              have_job;
	logic [IDX_W-1:0]  job_sel;
	logic [TW-1:0]     rem_sel;
	logic [SIM_W-1:0]  gap;
	logic [TW-1:0]     span_sel;
	logic [TW-1:0]     new_rem;
	logic [SIM_W-1:0]  new_t;
	logic              rec_we;
	logic              stat_we;
	logic [IDX_W-1:0]  stat_wa;
	logic [STAT_W-1:0] stat_wd;
	logic [IDX_W-1:0]  rd_addr;
	logic [SIM_W-1:0]  wait_t;
	logic [IX_W-1:0]   idx_x;
	logic [CX_W-1:0]   comp_x;
	logic [TX_W-1:0]   tat_x;
	logic [TX_W-1:0]   wait_x;

	assign {h_arr, h_burst, h_prio, h_zero, h_last} = q_head;
	assign {r_arr, r_burst, r_prio} = rec_rd_q;
	assign {r_rem, r_comp} = stat_rd_q;

	assign q_pop   = (state_q == ST_LOAD) && !q_status.empty;
	assign rd_addr = idx_q[IDX_W-1:0];

	// Scan evaluation on the registered read of one job
	assign arrived   = (SIM_W'(r_arr) <= t_q);
	assign live      = (r_rem != '0);
	assign take      = arrived && live && ({1'b0, r_prio} < best_prio_q);
	assign nxt_take  = live && !arrived && (!nxt_found_q || (r_arr < nxt_q));
	assign eval_last = (CNT_W'(eval_idx_s1) + CNT_W'(1) == cnt_q);
	assign issue_last = (idx_q + CNT_W'(1) == cnt_q);

	// Span selection: run to completion or to the next arrival
	assign have_job = best_found_q || run_valid_q;
	assign job_sel  = best_found_q ? best_idx_q : run_job_q;
	assign rem_sel  = best_found_q ? best_rem_q : run_rem_q;
	assign gap      = SIM_W'(nxt_q) - t_q;
	assign span_sel = (nxt_found_q && (gap < SIM_W'(rem_sel))) ? gap[TW-1:0] : rem_sel;

	assign new_rem = run_rem_q - span_q;
	assign new_t   = t_q + SIM_W'(span_q);

	assign rec_we  = q_pop;
	assign stat_we = q_pop || (state_q == ST_COMMIT);
	assign stat_wa = (state_q == ST_LOAD) ? cnt_q[IDX_W-1:0] : run_job_q;
	assign stat_wd = (state_q == ST_LOAD) ? {h_burst, SIM_W'(h_arr)} : {new_rem, new_t};

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[cnt_q[IDX_W-1:0]] <= {h_arr, h_burst, h_prio};
		end
		if (stat_we) begin
			stat_mem[stat_wa] <= stat_wd;
		end
		rec_rd_q  <= rec_mem[rd_addr];
		stat_rd_q <= stat_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			cnt_q        <= '0;
			done_q       <= '0;
			idx_q        <= '0;
			t_q          <= '0;
			run_job_q    <= '0;
			run_valid_q  <= 1'b0;
			run_prio_q   <= PRIO_NONE;
			run_rem_q    <= '0;
			span_q       <= '0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_prio_q  <= PRIO_NONE;
			best_rem_q   <= '0;
			nxt_found_q  <= 1'b0;
			nxt_q        <= '0;
			eval_v_s1    <= 1'b0;
			eval_idx_s1  <= '0;
			em_v_s1      <= 1'b0;
			em_idx_s1    <= '0;
			em_last_s1   <= 1'b0;
		end else begin
			eval_v_s1 <= 1'b0;
			em_v_s1   <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (!q_status.empty) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (h_zero) begin
							done_q <= done_q + CNT_W'(1);
						end
						if (h_last) begin
							t_q         <= '0;
							run_valid_q <= 1'b0;
							run_prio_q  <= PRIO_NONE;
							state_q     <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					idx_q        <= '0;
					best_found_q <= 1'b0;
					best_prio_q  <= run_prio_q;
					nxt_found_q  <= 1'b0;
					state_q      <= (done_q == cnt_q) ? ST_EMIT : ST_SCAN;
				end
				ST_SCAN: begin
					if (idx_q < cnt_q) begin
						eval_v_s1   <= 1'b1;
						eval_idx_s1 <= idx_q[IDX_W-1:0];
						idx_q       <= idx_q + CNT_W'(1);
					end
					if (eval_v_s1) begin
						if (take) begin
							best_found_q <= 1'b1;
							best_idx_q   <= eval_idx_s1;
							best_prio_q  <= {1'b0, r_prio};
							best_rem_q   <= r_rem;
						end
						if (nxt_take) begin
							nxt_found_q <= 1'b1;
							nxt_q       <= r_arr;
						end
						if (run_valid_q && (eval_idx_s1 == run_job_q)) begin
							run_rem_q <= r_rem;
						end
						if (eval_last) begin
							state_q <= ST_SPAN;
						end
					end
				end
				ST_SPAN: begin
					if (!have_job) begin
						t_q     <= SIM_W'(nxt_q);
						state_q <= ST_CHECK;
					end else begin
						run_job_q   <= job_sel;
						run_rem_q   <= rem_sel;
						span_q      <= span_sel;
						run_valid_q <= 1'b1;
						if (best_found_q) begin
							run_prio_q <= best_prio_q;
						end
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					t_q       <= new_t;
					run_rem_q <= new_rem;
					if (new_rem == '0) begin
						done_q      <= done_q + CNT_W'(1);
						run_valid_q <= 1'b0;
						run_prio_q  <= PRIO_NONE;
					end
					state_q <= ST_CHECK;
				end
				ST_EMIT: begin
					if (idx_q < cnt_q) begin
						em_v_s1    <= 1'b1;
						em_idx_s1  <= idx_q[IDX_W-1:0];
						em_last_s1 <= issue_last;
						idx_q      <= idx_q + CNT_W'(1);
						if (issue_last) begin
							cnt_q   <= '0;
							done_q  <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Result pipeline: turnaround, then waiting time clamped at zero
	assign wait_t = (tat_s2 >= SIM_W'(burst_s2)) ? (tat_s2 - SIM_W'(burst_s2)) : '0;
	assign idx_x  = IX_W'(em_idx_s2);
	assign comp_x = CX_W'(comp_s2);
	assign tat_x  = TX_W'(tat_s2);
	assign wait_x = TX_W'(wait_t);

	always_ff @(posedge clk) begin
		em_idx_s2  <= em_idx_s1;
		em_last_s2 <= em_last_s1;
		comp_s2    <= r_comp;
		tat_s2     <= r_comp - SIM_W'(r_arr);
		burst_s2   <= r_burst;
		result_q.job_index       <= idx_x[pps_pkg::OUT_INDEX_W-1:0];
		result_q.completion_time <= comp_x[pps_pkg::OUT_COMP_W-1:0];
		result_q.turnaround_time <= tat_x[pps_pkg::OUT_TURN_W-1:0];
		result_q.waiting_time    <= wait_x[pps_pkg::OUT_TURN_W-1:0];
		result_q.last_result     <= em_last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_s2  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			em_v_s2  <= em_v_s1;
			strobe_q <= em_v_s2;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) done_q <= cnt_q)
		else $error("finished job count exceeds loaded job count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |-> (span_q != '0) && (span_q <= run_rem_q))
		else $error("service span is zero or exceeds remaining burst");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPAN) && !best_found_q && !run_valid_q |-> nxt_found_q)
		else $error("processor idle with no future arrival");

	assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> (run_prio_q != PRIO_NONE))
		else $error("running job carries the empty priority");
`endif

endmodule

[src/preemptive_priority_scheduler_unit.sv]
// Top level of the preemptive priority scheduler: front end, record queue and
// scheduling back end. Depends on pps_pkg, pps_front, pps_queue and pps_back.
//
// Load a batch of job records with start while busy is low; one record is
// taken per cycle. A record with final_job set, or the one that fills the
// last of MAX_JOBS slots, closes the batch. The back end then replays
// preemptive priority scheduling event by event: each event scans all N jobs
// through the job memory's single read port, then advances time in the span
// and commit states to the next completion or arrival. A batch has at most
// 2N events. Results leave in load order, one per cycle, each held for exactly
// one cycle while strobe is high; the receiver cannot stall them, so capture
// every strobe. Records of the next batch are queued (up to four) while a
// batch runs; busy rises only when that queue is full.
module preemptive_priority_scheduler_unit #(
	parameter int MAX_JOBS       = 16,
	parameter int TIME_WIDTH     = 16,
	parameter int PRIORITY_WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pps_pkg::job_t    job,
	output logic             strobe,
	output pps_pkg::result_t result
);

	// Queue entry: arrival, burst, priority, zero-burst tag, end-of-batch tag
	localparam int Q_W = 2*TIME_WIDTH + PRIORITY_WIDTH + 2;

	logic               push;
	logic [Q_W-1:0]     push_data;
	logic               pop;
	logic [Q_W-1:0]     head;
	pps_pkg::q_status_t q_status;

	// Classify and transfer each accepted record into the queue
	pps_front #(
		.MAX_JOBS       (MAX_JOBS),
		.TIME_WIDTH     (TIME_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.job       (job),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	// Hold records while the back end schedules the previous batch
	pps_queue #(
		.W (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	// Load, schedule and stream results
	pps_back #(
		.MAX_JOBS       (MAX_JOBS),
		.TIME_WIDTH     (TIME_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_head   (head),
		.q_pop    (pop),
		.strobe   (strobe),
		.result   (result)
	);

endmodule
